// ===== src/gde_pkg.sv =====
// Shared types, result kind codes and helpers for the gamepad edge and
// dead zone core. No dependencies.
package gde_pkg;

    localparam logic [1:0] KIND_RELEASED = 2'd0;
    localparam logic [1:0] KIND_PRESSED  = 2'd1;
    localparam logic [1:0] KIND_ANALOG   = 2'd2;

    localparam logic CFG_TRIGGER = 1'b0;
    localparam logic CFG_THUMB   = 1'b1;

    localparam logic [7:0]  TRIG_FULL = 8'd255;
    localparam logic [14:0] THUMB_MAX = 15'd32767;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] rel;
        logic [15:0] prs;
        logic [7:0]  lt;
        logic [7:0]  rt;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  pad_index;
        logic [3:0]  button_bit;
        logic [15:0] lt_level;
        logic [15:0] rt_level;
        logic [15:0] lx_level;
        logic [15:0] ly_level;
        logic [15:0] rx_level;
        logic [15:0] ry_level;
        logic        last;
    } res_t;

    // Index of the lowest set bit; 0 when none.
    function automatic logic [3:0] lowest_bit(input logic [15:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/gde_fifo.sv =====
// Two-entry queue of decoded reports between front and back.
// Depends on gde_pkg.
module gde_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gde_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output gde_pkg::job_t rdata
);
    gde_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign rdata    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty |-> !pop) else $error("queue read while empty");
endmodule

// ===== src/gde_front.sv =====
// Front end: accepts reports, keeps held buttons per pad, queues edge masks.
// Depends on gde_pkg.
module gde_front #(
    parameter int PAD_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [103:0]  in_data,
    input  logic          q_full,
    output logic          q_push,
    output gde_pkg::job_t q_data
);
    localparam int PIW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic [15:0]    held_reg [PAD_COUNT];
    logic [1:0]     pad;
    logic [15:0]    now_bits;
    logic [PIW+1:0] padx;
    logic [PIW-1:0] idx;
    logic           pad_ok;
    logic           accept;
    logic [15:0]    old_bits;

    assign pad      = in_data[1:0];
    assign now_bits = in_data[17:2];
    assign padx     = {PIW'(0), pad};
    assign idx      = padx[PIW-1:0];
    assign pad_ok   = (padx < (PIW+2)'(PAD_COUNT));
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign old_bits = pad_ok ? held_reg[idx] : 16'd0;
    // Reports for pads out of range are taken and dropped.
    assign q_push   = accept && pad_ok;

    always_comb
    begin
        q_data.pad = pad;
        q_data.rel = old_bits & ~now_bits;
        q_data.prs = now_bits & ~old_bits;
        q_data.lt  = in_data[25:18];
        q_data.rt  = in_data[33:26];
        q_data.lx  = in_data[49:34];
        q_data.ly  = in_data[65:50];
        q_data.rx  = in_data[81:66];
        q_data.ry  = in_data[97:82];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                held_reg[i] <= 16'd0;
            end
        end
        else if (q_push)
        begin
            held_reg[idx] <= now_bits;
        end
    end
endmodule

// ===== src/gde_div.sv =====
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Caller guarantees the quotient fits in 17 bits. No dependencies.
module gde_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [46:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [16:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [16:0] low_reg, low_next;
    logic [16:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic        take;

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign trial    = {rem_reg, low_reg[16]};
    assign take     = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = {2'b00, dividend[46:17]};
            low_next  = dividend[16:0];
            dvs_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            low_next = {low_reg[15:0], 1'b0};
            quo_next = {quo_reg[15:0], take};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end
endmodule

// ===== src/gde_back.sv =====
// Back end: emits button events and computes the analog result with a
// shared multiplier, square root stepper and divider. Depends on gde_pkg, gde_div.
module gde_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    trig_thr,
    input  logic [14:0]   thumb_thr,
    input  logic          q_nonempty,
    input  gde_pkg::job_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output gde_pkg::res_t out_res
);
    localparam logic [3:0] C_IDLE  = 4'd0;
    localparam logic [3:0] C_TRIG  = 4'd1;
    localparam logic [3:0] C_TWAIT = 4'd2;
    localparam logic [3:0] C_SQA   = 4'd3;
    localparam logic [3:0] C_SQB   = 4'd4;
    localparam logic [3:0] C_SUM   = 4'd5;
    localparam logic [3:0] C_ROOT  = 4'd6;
    localparam logic [3:0] C_CHK   = 4'd7;
    localparam logic [3:0] C_DEN   = 4'd8;
    localparam logic [3:0] C_NUMX  = 4'd9;
    localparam logic [3:0] C_DIVX  = 4'd10;
    localparam logic [3:0] C_NUMY  = 4'd11;
    localparam logic [3:0] C_DIVY  = 4'd12;
    localparam logic [3:0] C_DONE  = 4'd13;

    gde_pkg::job_t job_reg;
    logic          active_reg;
    logic [15:0]   rel_reg, prs_reg;
    logic          out_valid_reg;
    gde_pkg::res_t out_reg;

    logic [3:0]  st_reg, st_next;
    logic        ch_reg, ch_next;
    logic [46:0] prod_reg;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] rad_reg, rad_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] bit_reg, bit_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] den_reg, den_next;
    logic [29:0] num_reg, num_next;
    logic [15:0] lvl_reg [6];
    logic [15:0] lvl_next [6];

    logic        load;
    logic        slot_free;
    logic        calc_done;
    logic [16:0] mul_a;
    logic [29:0] mul_b;
    logic        div_start;
    logic [46:0] div_dvd;
    logic [31:0] div_dvs;
    logic        div_busy;
    logic [16:0] div_q;

    logic [7:0]  t_raw;
    logic [7:0]  t_c;
    logic        t_zero;
    logic [15:0] sx_raw, sy_raw;
    logic [16:0] ax, ay;
    logic [32:0] root_try;
    logic [15:0] m;
    logic [14:0] mc;
    logic [14:0] q_sat;
    logic [15:0] q_pos;
    logic        axis_neg;

    gde_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign calc_done = (st_reg == C_DONE);
    assign slot_free = !out_valid_reg || out_ready;
    assign load      = !active_reg && q_nonempty;
    assign q_pop     = load;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Operand selection for the current channel.
    always_comb
    begin
        t_raw    = ch_reg ? job_reg.rt : job_reg.lt;
        t_zero   = (trig_thr >= gde_pkg::TRIG_FULL) || (t_raw < trig_thr);
        t_c      = t_raw - trig_thr;
        sx_raw   = ch_reg ? job_reg.rx : job_reg.lx;
        sy_raw   = ch_reg ? job_reg.ry : job_reg.ly;
        ax       = sx_raw[15] ? 17'(17'h10000 - {1'b0, sx_raw}) : {1'b0, sx_raw};
        ay       = sy_raw[15] ? 17'(17'h10000 - {1'b0, sy_raw}) : {1'b0, sy_raw};
        root_try = {1'b0, root_reg} + {1'b0, bit_reg};
        m        = root_reg[15:0];
        mc       = (m > {1'b0, gde_pkg::THUMB_MAX}) ? gde_pkg::THUMB_MAX : m[14:0];
        q_sat    = (div_q > {2'b00, gde_pkg::THUMB_MAX}) ? gde_pkg::THUMB_MAX
                                                         : div_q[14:0];
        axis_neg = (st_reg == C_DIVX) ? sx_raw[15] : sy_raw[15];
        q_pos    = {1'b0, q_sat};
    end

    always_comb
    begin
        unique case (st_reg)
            C_SQA:
            begin
                mul_a = ax;
                mul_b = {13'd0, ax};
            end
            C_SQB:
            begin
                mul_a = ay;
                mul_b = {13'd0, ay};
            end
            C_CHK:
            begin
                mul_a = {1'b0, m};
                mul_b = {15'd0, 15'(gde_pkg::THUMB_MAX - thumb_thr)};
            end
            C_DEN:
            begin
                mul_a = ax;
                mul_b = num_reg;
            end
            C_DIVX:
            begin
                mul_a = ay;
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = 17'd0;
                mul_b = 30'd0;
            end
        endcase
    end

    always_comb
    begin
        st_next   = st_reg;
        ch_next   = ch_reg;
        sum_next  = sum_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        for (int i = 0; i < 6; i++)
        begin
            lvl_next[i] = lvl_reg[i];
        end
        div_start = 1'b0;
        div_dvd   = prod_reg;
        div_dvs   = den_reg;

        if (load)
        begin
            st_next = C_TRIG;
            ch_next = 1'b0;
        end
        else
        begin
            unique case (st_reg) inside
                C_IDLE, C_DONE:
                begin
                    st_next = st_reg;
                end
                C_TRIG:
                begin
                    if (t_zero)
                    begin
                        lvl_next[{2'b00, ch_reg}] = 16'd0;
                        ch_next = !ch_reg;
                        st_next = ch_reg ? C_SQA : C_TRIG;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_dvd   = 47'({t_c, 16'd0} - {16'd0, t_c});
                        div_dvs   = {24'd0, 8'(gde_pkg::TRIG_FULL - trig_thr)};
                        st_next   = C_TWAIT;
                    end
                end
                C_TWAIT:
                begin
                    if (!div_busy)
                    begin
                        lvl_next[{2'b00, ch_reg}] = div_q[15:0];
                        ch_next = !ch_reg;
                        st_next = ch_reg ? C_SQA : C_TRIG;
                    end
                end
                C_SQA:
                begin
                    st_next = C_SQB;
                end
                C_SQB:
                begin
                    sum_next = prod_reg[31:0];
                    st_next  = C_SUM;
                end
                C_SUM:
                begin
                    rad_next  = sum_reg + prod_reg[31:0];
                    root_next = 32'd0;
                    bit_next  = 32'h4000_0000;
                    cnt_next  = 4'd0;
                    st_next   = C_ROOT;
                end
                C_ROOT:
                begin
                    if ({1'b0, rad_reg} >= root_try)
                    begin
                        rad_next  = rad_reg - root_try[31:0];
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        st_next = C_CHK;
                    end
                end
                C_CHK:
                begin
                    if ((m <= {1'b0, thumb_thr}) || (thumb_thr == gde_pkg::THUMB_MAX))
                    begin
                        lvl_next[{ch_reg, 1'b0} + 3'd2] = 16'd0;
                        lvl_next[{ch_reg, 1'b1} + 3'd2] = 16'd0;
                        ch_next = !ch_reg;
                        st_next = ch_reg ? C_DONE : C_SQA;
                    end
                    else
                    begin
                        num_next = {15'(mc - thumb_thr), 15'd0};
                        st_next  = C_DEN;
                    end
                end
                C_DEN:
                begin
                    den_next = prod_reg[31:0];
                    st_next  = C_NUMX;
                end
                C_NUMX:
                begin
                    div_start = 1'b1;
                    st_next   = C_DIVX;
                end
                C_DIVX:
                begin
                    if (!div_busy)
                    begin
                        lvl_next[{ch_reg, 1'b0} + 3'd2] = axis_neg ? 16'(-q_pos) : q_pos;
                        st_next = C_NUMY;
                    end
                end
                C_NUMY:
                begin
                    div_start = 1'b1;
                    st_next   = C_DIVY;
                end
                C_DIVY:
                begin
                    if (!div_busy)
                    begin
                        lvl_next[{ch_reg, 1'b1} + 3'd2] = axis_neg ? 16'(-q_pos) : q_pos;
                        ch_next = !ch_reg;
                        st_next = ch_reg ? C_DONE : C_SQA;
                    end
                end
                default:
                begin
                    st_next = C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= C_IDLE;
            ch_reg        <= 1'b0;
            cnt_reg       <= 4'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            ch_reg  <= ch_next;
            cnt_reg <= cnt_next;
            if (load)
            begin
                active_reg <= 1'b1;
            end
            else if (active_reg && slot_free && rel_reg == 16'd0 && prs_reg == 16'd0
                     && calc_done)
            begin
                active_reg <= 1'b0;
            end
            if (slot_free)
            begin
                out_valid_reg <= active_reg && !load
                                 && (rel_reg != 16'd0 || prs_reg != 16'd0 || calc_done);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 47'(mul_a * mul_b);
        sum_reg  <= sum_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        for (int i = 0; i < 6; i++)
        begin
            lvl_reg[i] <= lvl_next[i];
        end
        if (load)
        begin
            job_reg <= q_data;
            rel_reg <= q_data.rel;
            prs_reg <= q_data.prs;
        end
        else if (active_reg && slot_free)
        begin
            out_reg.pad_index  <= job_reg.pad;
            out_reg.lt_level   <= 16'd0;
            out_reg.rt_level   <= 16'd0;
            out_reg.lx_level   <= 16'd0;
            out_reg.ly_level   <= 16'd0;
            out_reg.rx_level   <= 16'd0;
            out_reg.ry_level   <= 16'd0;
            out_reg.last       <= 1'b0;
            out_reg.button_bit <= 4'd0;
            if (rel_reg != 16'd0)
            begin
                out_reg.kind       <= gde_pkg::KIND_RELEASED;
                out_reg.button_bit <= gde_pkg::lowest_bit(rel_reg);
                rel_reg            <= rel_reg & (rel_reg - 16'd1);
            end
            else if (prs_reg != 16'd0)
            begin
                out_reg.kind       <= gde_pkg::KIND_PRESSED;
                out_reg.button_bit <= gde_pkg::lowest_bit(prs_reg);
                prs_reg            <= prs_reg & (prs_reg - 16'd1);
            end
            else
            begin
                out_reg.kind     <= gde_pkg::KIND_ANALOG;
                out_reg.lt_level <= lvl_reg[0];
                out_reg.rt_level <= lvl_reg[1];
                out_reg.lx_level <= lvl_reg[2];
                out_reg.ly_level <= lvl_reg[3];
                out_reg.rx_level <= lvl_reg[4];
                out_reg.ry_level <= lvl_reg[5];
                out_reg.last     <= 1'b1;
            end
        end
    end

    a_last_on_analog: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == (out_reg.kind == gde_pkg::KIND_ANALOG)))
        else $error("last flag does not match result kind");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy) else $error("divider started while busy");
    a_load_idle_calc: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (st_reg == C_IDLE || st_reg == C_DONE))
        else $error("new report loaded while analog path busy");
endmodule

// ===== src/gamepad_edge_and_deadzone_core.sv =====
// Top level of the gamepad edge and dead zone core: ports, config registers,
// front end, queue and back end. Depends on gde_pkg, gde_front, gde_fifo, gde_back.
//
//  channel   | direction | moves
//  s_axis    | in        | one report per transfer
//  m_axis    | out       | released, pressed, then one analog result (tlast)
//  cfg       | in        | threshold register writes
//
// The back end loads the next queued report once it frees up, then works through the
// analog path: per trigger one 17-step division, per stick two squares, a
// 16-step square root and two 17-step divisions; a trigger or stick in its dead
// zone skips its divisions. Button events go out one per cycle meanwhile while
// m_axis_tready stays high; the analog result follows them. Two reports queue ahead
// of the back end. Reset clears held buttons and loads thresholds 30 and 8000.
module gamepad_edge_and_deadzone_core #(
    parameter int PAD_COUNT = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pad, buttons, left_trigger_raw, right_trigger_raw, left_x_raw,
    // left_y_raw, right_x_raw, right_y_raw, zero fill
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pad_index, button_bit, left_trigger_level, right_trigger_level,
    // left_x_level, left_y_level, right_x_level, right_y_level, zero fill
    output logic [103:0] m_axis_tdata,
    // kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [14:0]  cfg_data
);
    logic [7:0]    trig_thr_reg;
    logic [14:0]   thumb_thr_reg;
    logic          q_push, q_full, q_pop, q_nonempty;
    gde_pkg::job_t q_wdata, q_rdata;
    gde_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_thr_reg  <= 8'd30;
            thumb_thr_reg <= 15'd8000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gde_pkg::CFG_TRIGGER: trig_thr_reg  <= cfg_data[7:0];
                gde_pkg::CFG_THUMB:   thumb_thr_reg <= cfg_data;
                default:              trig_thr_reg  <= trig_thr_reg;
            endcase
        end
    end

    gde_front #(.PAD_COUNT(PAD_COUNT)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    gde_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    (q_rdata)
    );

    gde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_thr   (trig_thr_reg),
        .thumb_thr  (thumb_thr_reg),
        .q_nonempty (q_nonempty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {2'b00, res.ry_level, res.rx_level, res.ly_level, res.lx_level,
                           res.rt_level, res.lt_level, res.button_bit, res.pad_index};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule
